// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/pfsf_pkg.sv =====
// Shared types, constants and helpers of the page framebuffer span fill block.
package pfsf_pkg;

  localparam int DISPLAY_WIDTH  = 128;
  localparam int DISPLAY_HEIGHT = 64;

  localparam int STORE_DEPTH = 1024;
  localparam int STORE_AW    = 10;
  localparam int BYTE_W      = 8;

  localparam int PAGES    = (DISPLAY_HEIGHT + 7) / 8;
  localparam int FULL_AW  = $clog2(DISPLAY_WIDTH * PAGES);
  localparam int ADDR_W   = (FULL_AW > STORE_AW) ? FULL_AW : STORE_AW;
  localparam int MAX_DIM  = (DISPLAY_WIDTH > DISPLAY_HEIGHT) ? DISPLAY_WIDTH : DISPLAY_HEIGHT;
  localparam int COORD_W  = $clog2(MAX_DIM + 1);
  localparam int CNT_W    = $clog2(DISPLAY_WIDTH);

  localparam int OP_W    = 3;
  localparam int COORD_IN_W = 16;
  localparam int COLOR_W = 2;
  localparam int CALC_W  = COORD_IN_W + 2;

  typedef enum logic [OP_W-1:0] {
    OP_PIXEL = 3'd0,
    OP_HSPAN = 3'd1,
    OP_VSPAN = 3'd2,
    OP_READ  = 3'd3,
    OP_CLEAR = 3'd4
  } op_e;

  typedef enum logic [COLOR_W-1:0] {
    COL_CLEAR  = 2'd0,
    COL_SET    = 2'd1,
    COL_INVERT = 2'd2,
    COL_NONE   = 2'd3
  } color_e;

  typedef struct packed {
    logic [OP_W-1:0]              op;
    logic signed [COORD_IN_W-1:0] x;
    logic signed [COORD_IN_W-1:0] y;
    logic signed [COORD_IN_W-1:0] length;
    color_e                       color;
    logic [STORE_AW-1:0]          read_index;
  } item_t;

  // Walk plan for one drawing item: a run of byte addresses with masks.
  typedef struct packed {
    logic              draw;
    logic              step_page;   // step by one page row instead of one byte
    logic [ADDR_W-1:0] first_addr;
    logic [CNT_W-1:0]  count;       // bytes to touch, minus one
    logic [BYTE_W-1:0] mask_first;
    logic [BYTE_W-1:0] mask_last;
    logic [BYTE_W-1:0] mask_mid;
  } plan_t;

  function automatic logic [BYTE_W-1:0] paint_byte(logic [BYTE_W-1:0] old,
                                                   logic [BYTE_W-1:0] mask,
                                                   color_e color);
    logic [BYTE_W-1:0] res;
    unique case (color)
      COL_CLEAR:  res = old & ~mask;
      COL_SET:    res = old | mask;
      COL_INVERT: res = old ^ mask;
      COL_NONE:   res = old;
    endcase
    return res;
  endfunction

endpackage

// ===== hw/rtl/page_framebuffer_span_fill.sv =====
// Top level of the monochrome page framebuffer with pixel and span drawing.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------------------------------
//  input    | in        | in_valid_i / in_stall_o   | operation, x, y, length, color,
//           |           |                           | read_index
//  result   | out       | out_valid_o / out_stall_i | read_data
//
// Work: the single port of the frame store serialises each item: every byte touched is
//   read, then written back. A vertical span touches at most 8 pages; a clear sweeps all
//   1024 bytes of the store.
// Reset: a clearing pass zeroes all 1024 bytes of the store; in_stall_o stays high throughout.
// Stalls: one item is in work at a time; its result waits in the output register while
//   the next transfer is already taken.
module page_framebuffer_span_fill (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [pfsf_pkg::OP_W-1:0]         operation_i,
  input  logic signed [pfsf_pkg::COORD_IN_W-1:0] x_i,
  input  logic signed [pfsf_pkg::COORD_IN_W-1:0] y_i,
  input  logic signed [pfsf_pkg::COORD_IN_W-1:0] length_i,
  input  logic [pfsf_pkg::COLOR_W-1:0]      color_i,
  input  logic [pfsf_pkg::STORE_AW-1:0]     read_index_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pfsf_pkg::BYTE_W-1:0]       read_data_o
);

  typedef enum logic [2:0] {
    S_CLEAR,   // sweep zeros through the store
    S_IDLE,    // wait for an input transfer
    S_PLAN,    // decode the item, issue a read for the read-byte operation
    S_READ,    // read the byte under the walk pointer
    S_MODIFY,  // paint and write back, then step
    S_FETCH,   // capture the read-byte data
    S_DONE     // hand the result to the output register
  } state_e;

  state_e                         state_q;
  logic                           pending_q;
  logic [pfsf_pkg::STORE_AW-1:0]  clr_q;
  pfsf_pkg::item_t                item_q;
  pfsf_pkg::plan_t                plan_q;
  pfsf_pkg::plan_t                plan;
  logic [pfsf_pkg::ADDR_W-1:0]    addr_q;
  logic [pfsf_pkg::CNT_W-1:0]     cnt_q;
  logic                           first_q;
  logic [pfsf_pkg::BYTE_W-1:0]    result_q;
  logic                           out_valid_q;
  logic [pfsf_pkg::BYTE_W-1:0]    read_data_q;

  logic                           in_xfer;
  logic                           out_free;
  logic                           in_store;
  logic [pfsf_pkg::BYTE_W-1:0]    mask;
  logic                           ram_we;
  logic [pfsf_pkg::STORE_AW-1:0]  ram_addr;
  logic [pfsf_pkg::BYTE_W-1:0]    ram_wdata;
  logic [pfsf_pkg::BYTE_W-1:0]    ram_rdata;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

  pfsf_plan u_plan (
    .item_i (item_q),
    .plan_o (plan)
  );

  // Bytes the display geometry puts past the store are never written.
  assign in_store = ({1'b0, addr_q} < (pfsf_pkg::ADDR_W + 1)'(pfsf_pkg::STORE_DEPTH));
  assign mask = (first_q ? plan_q.mask_first : 8'hFF)
              & ((cnt_q == '0) ? plan_q.mask_last : 8'hFF)
              & plan_q.mask_mid;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = addr_q[pfsf_pkg::STORE_AW-1:0];
    ram_wdata = pfsf_pkg::paint_byte(ram_rdata, mask, item_q.color);
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
      end
      S_PLAN:   ram_addr = item_q.read_index;
      S_MODIFY: ram_we   = in_store;
      S_IDLE, S_READ, S_FETCH, S_DONE: ram_we = 1'b0;
    endcase
  end

  pfsf_ram #(
    .WIDTH (pfsf_pkg::BYTE_W),
    .DEPTH (pfsf_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Item payload and walk registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.op         <= operation_i;
      item_q.x          <= x_i;
      item_q.y          <= y_i;
      item_q.length     <= length_i;
      item_q.color      <= pfsf_pkg::color_e'(color_i);
      item_q.read_index <= read_index_i;
    end
    if (state_q == S_PLAN) begin
      plan_q  <= plan;
      addr_q  <= plan.first_addr;
      cnt_q   <= plan.count;
      first_q <= 1'b1;
    end else if (state_q == S_MODIFY) begin
      addr_q  <= addr_q + (plan_q.step_page
                 ? pfsf_pkg::ADDR_W'(pfsf_pkg::DISPLAY_WIDTH)
                 : pfsf_pkg::ADDR_W'(1));
      cnt_q   <= cnt_q - pfsf_pkg::CNT_W'(1);
      first_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      pending_q   <= 1'b0;
      clr_q       <= '0;
      result_q    <= '0;
      out_valid_q <= 1'b0;
      read_data_q <= '0;
    end else begin
      // a new result loads the output register, a taken one empties it
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + pfsf_pkg::STORE_AW'(1);
          if (clr_q == pfsf_pkg::STORE_AW'(pfsf_pkg::STORE_DEPTH - 1)) begin
            state_q <= pending_q ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            pending_q <= 1'b1;
            state_q   <= S_PLAN;
          end
        end
        S_PLAN: begin
          result_q <= '0;
          unique case (item_q.op)
            pfsf_pkg::OP_PIXEL, pfsf_pkg::OP_HSPAN, pfsf_pkg::OP_VSPAN:
              state_q <= plan.draw ? S_READ : S_DONE;
            pfsf_pkg::OP_READ:  state_q <= S_FETCH;
            pfsf_pkg::OP_CLEAR: begin
              clr_q   <= '0;
              state_q <= S_CLEAR;
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_READ:   state_q <= S_MODIFY;
        S_MODIFY: state_q <= (cnt_q == '0) ? S_DONE : S_READ;
        S_FETCH: begin
          result_q <= ram_rdata;
          state_q  <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            read_data_q <= result_q;
            pending_q   <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/pfsf_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
module pfsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

// ===== hw/rtl/pfsf_plan.sv =====
// Clips a pixel or span item to the display and turns it into a byte walk plan.
module pfsf_plan (
  input  pfsf_pkg::item_t item_i,
  output pfsf_pkg::plan_t plan_o
);

  always_comb begin
    logic                               is_h;
    logic signed [pfsf_pkg::CALC_W-1:0] start_s, end_s, lim_s, lo_s, hi_s, last_s;
    logic signed [pfsf_pkg::CALC_W-1:0] x_s, y_s;
    logic                               x_in, y_in, span_ok;
    logic [pfsf_pkg::COORD_W-1:0]       x_c, y_c, lo_c, last_c;

    is_h    = (item_i.op == pfsf_pkg::OP_HSPAN);
    x_s     = pfsf_pkg::CALC_W'(item_i.x);
    y_s     = pfsf_pkg::CALC_W'(item_i.y);
    x_in    = (x_s >= 0) && (x_s < pfsf_pkg::CALC_W'(pfsf_pkg::DISPLAY_WIDTH));
    y_in    = (y_s >= 0) && (y_s < pfsf_pkg::CALC_W'(pfsf_pkg::DISPLAY_HEIGHT));
    start_s = is_h ? x_s : y_s;
    lim_s   = is_h ? pfsf_pkg::CALC_W'(pfsf_pkg::DISPLAY_WIDTH)
                   : pfsf_pkg::CALC_W'(pfsf_pkg::DISPLAY_HEIGHT);
    end_s   = start_s + pfsf_pkg::CALC_W'(item_i.length);
    lo_s    = (start_s < 0) ? '0 : start_s;
    hi_s    = (end_s > lim_s) ? lim_s : end_s;
    last_s  = hi_s - pfsf_pkg::CALC_W'(1);
    span_ok = (item_i.length > 0) && (lo_s < hi_s);
    x_c     = x_s[pfsf_pkg::COORD_W-1:0];
    y_c     = y_s[pfsf_pkg::COORD_W-1:0];
    lo_c    = lo_s[pfsf_pkg::COORD_W-1:0];
    last_c  = last_s[pfsf_pkg::COORD_W-1:0];

    plan_o            = '0;
    plan_o.mask_first = '1;
    plan_o.mask_last  = '1;
    plan_o.mask_mid   = '1;
    unique case (item_i.op)
      pfsf_pkg::OP_PIXEL: begin
        plan_o.draw       = x_in && y_in;
        plan_o.first_addr = pfsf_pkg::ADDR_W'(x_c)
                          + pfsf_pkg::ADDR_W'(y_c >> 3)
                          * pfsf_pkg::ADDR_W'(pfsf_pkg::DISPLAY_WIDTH);
        plan_o.mask_mid   = pfsf_pkg::BYTE_W'(1) << y_c[2:0];
      end
      pfsf_pkg::OP_HSPAN: begin
        plan_o.draw       = y_in && span_ok;
        plan_o.first_addr = pfsf_pkg::ADDR_W'(lo_c)
                          + pfsf_pkg::ADDR_W'(y_c >> 3)
                          * pfsf_pkg::ADDR_W'(pfsf_pkg::DISPLAY_WIDTH);
        plan_o.count      = pfsf_pkg::CNT_W'(last_c - lo_c);
        plan_o.mask_mid   = pfsf_pkg::BYTE_W'(1) << y_c[2:0];
      end
      pfsf_pkg::OP_VSPAN: begin
        plan_o.draw       = x_in && span_ok;
        plan_o.step_page  = 1'b1;
        plan_o.first_addr = pfsf_pkg::ADDR_W'(x_c)
                          + pfsf_pkg::ADDR_W'(lo_c >> 3)
                          * pfsf_pkg::ADDR_W'(pfsf_pkg::DISPLAY_WIDTH);
        plan_o.count      = pfsf_pkg::CNT_W'((last_c >> 3) - (lo_c >> 3));
        plan_o.mask_first = 8'hFF << lo_c[2:0];
        plan_o.mask_last  = 8'hFF >> (3'd7 - last_c[2:0]);
      end
      default: plan_o.draw = 1'b0;
    endcase
    if (item_i.color == pfsf_pkg::COL_NONE) begin
      plan_o.draw = 1'b0;
    end
  end

endmodule

// ===== hw/rtl/pfsf_checker.sv =====
// Port-level checker for the page framebuffer span fill block, with its bind.
`include "assert_macros.svh"

module pfsf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [pfsf_pkg::BYTE_W-1:0] read_data_o
);

  logic [1:0] outstanding_q;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      outstanding_q <= outstanding_q + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      outstanding_q <= outstanding_q - 2'd1;
    end
  end

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(read_data_o))
  `ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_xfer, in_stall_o)
  `ASSERT_IMPLIES(a_no_phantom, clk_i, rst_ni, out_valid_o, outstanding_q != 2'd0)
  `ASSERT_IMPLIES(a_bounded, clk_i, rst_ni, 1'b1, outstanding_q <= 2'd2)

endmodule

bind page_framebuffer_span_fill pfsf_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .read_data_o (read_data_o)
);

// ===== verif/page_framebuffer_span_fill_test.sv =====
// Self-checking testbench for the page framebuffer span fill block.
module page_framebuffer_span_fill_test;
  import pfsf_pkg::*;

  // Run bounds. The slowest item is a clear, then wide horizontal spans. The
  // limit covers the reset clearing pass and sits several times above a run
  // with every side stalling hard.
  localparam int CLK_PERIOD   = 10;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1950;
  localparam int IDLE_PERCENT = 38;

  // Unused operation codes: the block must ignore them and return zero.
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [OP_W-1:0]              operation = '0;
  logic signed [COORD_IN_W-1:0] x_coord = '0;
  logic signed [COORD_IN_W-1:0] y_coord = '0;
  logic signed [COORD_IN_W-1:0] span_len = '0;
  logic [COLOR_W-1:0]           color = '0;
  logic [STORE_AW-1:0]          read_index = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [BYTE_W-1:0]            read_data;

  // Items waiting to be driven, and the read bytes still owed by the block.
  item_t             item_q[$];
  item_t             cur_item;
  logic [BYTE_W-1:0] read_data_exp_q[$];
  logic [BYTE_W-1:0] want_byte;

  // Shadow copy of the frame store, updated in transfer order.
  logic [BYTE_W-1:0] shadow_store [STORE_DEPTH];

  int n_sent = 0;
  int n_queued = 0;
  int n_checked = 0;
  int n_errors = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  page_framebuffer_span_fill u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .operation_i  (operation),
    .x_i          (x_coord),
    .y_i          (y_coord),
    .length_i     (span_len),
    .color_i      (color),
    .read_index_i (read_index),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .read_data_o  (read_data)
  );

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Paint one pixel of the shadow store; pixels off the display are dropped.
  function automatic void paint_pixel(int px, int py, color_e c);
    int                addr;
    logic [BYTE_W-1:0] mask;
    if (px < 0 || px >= DISPLAY_WIDTH || py < 0 || py >= DISPLAY_HEIGHT) return;
    addr = px + (py / 8) * DISPLAY_WIDTH;
    // bytes past the end of the store are never written
    if (addr >= STORE_DEPTH) return;
    mask = 8'h01 << (py % 8);
    case (c)
      COL_CLEAR:  shadow_store[addr] = shadow_store[addr] & ~mask;
      COL_SET:    shadow_store[addr] = shadow_store[addr] | mask;
      COL_INVERT: shadow_store[addr] = shadow_store[addr] ^ mask;
      default:    ;
    endcase
  endfunction

  // Apply one item to the shadow store and give the byte the block returns.
  // Span ends are worked out in 32 bits, so start + length never wraps.
  function automatic logic [BYTE_W-1:0] draw_and_read(item_t it);
    int                px;
    int                py;
    int                len;
    int                lo;
    int                hi;
    logic [BYTE_W-1:0] data;
    px   = $signed(it.x);
    py   = $signed(it.y);
    len  = $signed(it.length);
    data = '0;
    case (it.op)
      OP_PIXEL: paint_pixel(px, py, it.color);
      OP_HSPAN: begin
        if (py >= 0 && py < DISPLAY_HEIGHT && len > 0) begin
          lo = (px < 0) ? 0 : px;
          hi = (px + len > DISPLAY_WIDTH) ? DISPLAY_WIDTH : px + len;
          for (int i = lo; i < hi; i++) paint_pixel(i, py, it.color);
        end
      end
      OP_VSPAN: begin
        if (px >= 0 && px < DISPLAY_WIDTH && len > 0) begin
          lo = (py < 0) ? 0 : py;
          hi = (py + len > DISPLAY_HEIGHT) ? DISPLAY_HEIGHT : py + len;
          for (int i = lo; i < hi; i++) paint_pixel(px, i, it.color);
        end
      end
      OP_READ:  data = shadow_store[it.read_index];
      OP_CLEAR: foreach (shadow_store[a]) shadow_store[a] = '0;
      default:  ;
    endcase
    return data;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Both sides idle at random, except in a calm window where every cycle
  // carries a transfer if one is ready.
  function automatic bit take_break();
    if (n_sent >= 700 && n_sent < 1000) return 1'b0;
    return $urandom_range(99) < IDLE_PERCENT;
  endfunction

  task automatic queue_item(logic [OP_W-1:0] op, int x, int y, int len, int c,
                            int idx);
    item_t it;
    it.op         = op;
    it.x          = COORD_IN_W'(x);
    it.y          = COORD_IN_W'(y);
    it.length     = COORD_IN_W'(len);
    it.color      = color_e'(c[1:0]);
    it.read_index = STORE_AW'(idx);
    item_q.push_back(it);
    n_queued++;
  endtask

  task automatic report_mismatch(string what, logic [BYTE_W-1:0] got,
                                 logic [BYTE_W-1:0] want);
    $display("mismatch: %s, got %02h want %02h at %0t", what, got, want, $time);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------
  // Driver: holds the payload steady until the transfer, predicting as each
  // item is taken so the shadow store follows the block's order of work.
  // ---------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        read_data_exp_q.push_back(draw_and_read(cur_item));
        n_sent++;
      end
      // new item only once the previous one has gone
      if (!in_valid || !in_stall) begin
        if (item_q.size() != 0 && !take_break()) begin
          cur_item = item_q.pop_front();
          in_valid   <= 1'b1;
          operation  <= cur_item.op;
          x_coord    <= cur_item.x;
          y_coord    <= cur_item.y;
          span_len   <= cur_item.length;
          color      <= cur_item.color;
          read_index <= cur_item.read_index;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every result transfer is matched against the oldest byte owed.
  // ---------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_checked++;
        if (read_data_exp_q.size() == 0) begin
          report_mismatch("result with nothing owed", read_data, '0);
        end else begin
          want_byte = read_data_exp_q.pop_front();
          if (read_data !== want_byte) report_mismatch("read_data", read_data, want_byte);
        end
      end
      out_stall <= take_break();
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    int r;
    int x;
    int y;
    int len;
    int idx;
    int last_addr;
    logic [OP_W-1:0] op;

    foreach (shadow_store[a]) shadow_store[a] = '0;
    last_addr = 0;

    // Directed: corners, clipping on each edge, empty spans, every colour
    // and operation code, and full-scale coordinates.
    queue_item(OP_PIXEL, 0, 0, 0, COL_SET, 0);
    queue_item(OP_READ, 0, 0, 0, COL_CLEAR, 0);
    queue_item(OP_PIXEL, 127, 63, -1, COL_SET, 1023);
    queue_item(OP_READ, -1, -1, -1, COL_NONE, 1023);
    // pixels just off the left, right and bottom edges, and at the extremes
    queue_item(OP_PIXEL, -1, 5, 1, COL_SET, 0);
    queue_item(OP_PIXEL, 128, 5, 1, COL_SET, 0);
    queue_item(OP_PIXEL, 5, 64, 1, COL_SET, 0);
    queue_item(OP_PIXEL, -32768, -32768, -32768, COL_INVERT, 0);
    queue_item(OP_PIXEL, 32767, 32767, 32767, COL_SET, 1023);
    // span ending left of the display, then clipped on the left and right
    queue_item(OP_HSPAN, -32768, 10, 32767, COL_SET, 0);
    queue_item(OP_HSPAN, -5, 9, 20, COL_SET, 0);
    queue_item(OP_HSPAN, 120, 63, 32767, COL_INVERT, 0);
    queue_item(OP_READ, 0, 0, 0, COL_SET, 128);
    // empty spans: zero and negative length, row off the display
    queue_item(OP_HSPAN, 0, 20, 0, COL_SET, 0);
    queue_item(OP_HSPAN, 0, 20, -32768, COL_SET, 0);
    queue_item(OP_HSPAN, 0, -1, 50, COL_SET, 0);
    queue_item(OP_HSPAN, 0, 64, 50, COL_SET, 0);
    // vertical spans: whole column, partial page, column off the display
    queue_item(OP_VSPAN, 3, -4, 100, COL_SET, 0);
    queue_item(OP_VSPAN, 3, 2, 3, COL_CLEAR, 0);
    queue_item(OP_VSPAN, 128, 0, 64, COL_SET, 0);
    queue_item(OP_VSPAN, -1, 0, 64, COL_SET, 0);
    queue_item(OP_READ, 0, 0, 0, COL_SET, 3);
    // no-effect colour, spare operations, then wipe
    queue_item(OP_HSPAN, 0, 0, 128, COL_NONE, 0);
    queue_item(OP_SPARE_LO, 32767, -32768, 32767, COL_SET, 1023);
    queue_item(OP_SPARE_MID, 1, 1, 1, COL_INVERT, 3);
    queue_item(OP_SPARE_HI, -1, -1, -1, COL_NONE, 1023);
    queue_item(OP_CLEAR, -1, -1, -1, COL_NONE, 1023);
    queue_item(OP_READ, 0, 0, 0, COL_SET, 3);

    // Random: mostly coordinates near the display so drawing really happens,
    // with a share of full-range values for the clipping paths.
    repeat (RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 22)      op = OP_PIXEL;
      else if (r < 44) op = OP_HSPAN;
      else if (r < 64) op = OP_VSPAN;
      else if (r < 92) op = OP_READ;
      else if (r < 93) op = OP_CLEAR;
      else             op = OP_SPARE_LO + OP_W'($urandom_range(2));

      x   = ($urandom_range(99) < 80) ? int'($urandom_range(143)) - 8 : int'($urandom);
      y   = ($urandom_range(99) < 80) ? int'($urandom_range(79)) - 8 : int'($urandom);
      len = int'($urandom);
      if (op == OP_HSPAN) begin
        r = $urandom_range(99);
        if (r < 60)      len = int'($urandom_range(24)) - 3;
        else if (r < 85) len = $urandom_range(140);
      end else if (op == OP_VSPAN) begin
        if ($urandom_range(99) < 80) len = int'($urandom_range(75)) - 4;
      end
      idx = $urandom_range(STORE_DEPTH - 1);
      if (op == OP_READ && $urandom_range(1) == 0) idx = last_addr;

      queue_item(op, x, y, len, $urandom_range(3), idx);

      // remember a byte that was just drawn so later reads land on it
      if (op <= OP_VSPAN && x >= 0 && x < DISPLAY_WIDTH && y >= 0 && y < DISPLAY_HEIGHT)
        last_addr = x + (y / 8) * DISPLAY_WIDTH;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // every queued item owes exactly one result transfer
    while (n_checked < n_queued) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(CYCLE_LIMIT * CLK_PERIOD);
    $display("status: fail");
    $finish;
  end

endmodule

// ===== page_framebuffer_span_fill.f =====
+incdir+hw/rtl
hw/rtl/pfsf_pkg.sv
hw/rtl/pfsf_ram.sv
hw/rtl/pfsf_plan.sv
hw/rtl/page_framebuffer_span_fill.sv
hw/rtl/pfsf_checker.sv
verif/page_framebuffer_span_fill_test.sv
